// File: sv/bbic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbic_pkg
// shared types and constants of the block bit inversion codec
// ----------------------------------------------------------------------------
package bbic_pkg;

   localparam int DATA_W  = 64;
   localparam int LEN_W   = 7;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   // register index within the csr map (byte address 4*index)
   typedef enum logic [1:0] {
      REG_BLOCK_LEN = 2'd0,
      REG_METHOD    = 2'd1,
      REG_DIRECTION = 2'd2
   } reg_idx_type;

   typedef enum logic [1:0] {
      CLASS_EQUAL      = 2'd0,
      CLASS_MORE_ZEROS = 2'd1,
      CLASS_MORE_ONES  = 2'd2
   } blk_class_type;

   localparam logic METHOD_INVERT = 1'b0;
   localparam logic DIR_ENCODE    = 1'b0;

   localparam logic [LEN_W-1:0] BLOCK_LEN_RESET = 7'd8;

   // position masks for a full 64-bit block, aligned to the top
   // even positions, and positions that are multiples of three
   localparam logic [DATA_W-1:0] POS_EVERY_2ND = 64'h5555_5555_5555_5555;
   localparam logic [DATA_W-1:0] POS_EVERY_3RD = 64'h2492_4924_9249_2492;

endpackage : bbic_pkg
`default_nettype wire

// File: sv/block_bit_inversion_codec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_bit_inversion_codec
// block coder: class-driven bit inversion or one-bit rotation per block
// path: an accepted request enters the input reg, then the result reg drives rsp_
// throughput: one transaction per cycle unless rsp_stall holds the result; the class of a block feeds the next
// block through one register updated in the same cycle as the result register (invert method only)
// reset: synchronous, active high; clears valid flags and the block class,
// registers return to block_len 8, method 0, direction 0
// ----------------------------------------------------------------------------
module block_bit_inversion_codec
   import bbic_pkg::*;
#(
   parameter int MAX_BLOCK = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   // request
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire  [DATA_W-1:0]       req_block_in,
   input  wire                     req_first_block,
   // response
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic [DATA_W-1:0]       rsp_block_out,
   // csr
   input  wire                     csr_psel,
   input  wire                     csr_penable,
   input  wire                     csr_pwrite,
   input  wire  [CSR_AW-1:0]       csr_paddr,
   input  wire  [CSR_DW-1:0]       csr_pwdata,
   output logic [CSR_DW-1:0]       csr_prdata,
   output logic                    csr_pready
);

   // registers
   logic [LEN_W-1:0]  block_len_ff, block_len_in;
   logic              method_ff, method_in;
   logic              direction_ff, direction_in;
   blk_class_type     prev_class_ff, prev_class_in;

   logic              s1_valid_ff, s1_valid_in;
   logic [DATA_W-1:0] s1_block_ff, s1_block_in;
   logic              s1_first_ff, s1_first_in;

   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_block_ff, out_block_in;

   // datapath
   logic              csr_write;
   reg_idx_type       csr_idx;
   logic              out_free;
   logic              advance;
   logic [LEN_W-1:0]  eff_len;
   logic [LEN_W-1:0]  top_gap;
   logic [LEN_W-1:0]  len_m1;
   logic [DATA_W-1:0] len_mask;
   logic [DATA_W-1:0] x;
   logic [DATA_W-1:0] inv_mask;
   logic [DATA_W-1:0] inv_out;
   logic [DATA_W-1:0] rot_out;
   logic [DATA_W-1:0] plain;
   logic [LEN_W-1:0]  ones;
   logic [LEN_W:0]    ones_x2;
   blk_class_type     cur_class;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = reg_idx_type'(csr_paddr[3:2]);

   always_comb begin
      csr_prdata = '0;
      case (csr_idx)
         REG_BLOCK_LEN: csr_prdata = {{(CSR_DW-LEN_W){1'b0}}, block_len_ff};
         REG_METHOD:    csr_prdata = {{(CSR_DW-1){1'b0}}, method_ff};
         REG_DIRECTION: csr_prdata = {{(CSR_DW-1){1'b0}}, direction_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_comb begin
      block_len_in = block_len_ff;
      method_in    = method_ff;
      direction_in = direction_ff;
      if (csr_write) begin
         case (csr_idx)
            REG_BLOCK_LEN: block_len_in = csr_pwdata[LEN_W-1:0];
            REG_METHOD:    method_in    = csr_pwdata[0];
            REG_DIRECTION: direction_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // handshake
   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign advance   = s1_valid_ff & out_free;
   assign req_stall = s1_valid_ff & ~out_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_block_in = s1_block_ff;
      s1_first_in = s1_first_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         s1_valid_in = 1'b1;
         s1_block_in = req_block_in;
         s1_first_in = req_first_block;
      end
   end

   // effective length and masks
   always_comb begin
      if (block_len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (block_len_ff > LEN_W'(MAX_BLOCK)) begin
         eff_len = LEN_W'(MAX_BLOCK);
      end else begin
         eff_len = block_len_ff;
      end
   end

   assign top_gap  = LEN_W'(DATA_W) - eff_len;
   assign len_m1   = eff_len - LEN_W'(1);
   assign len_mask = {DATA_W{1'b1}} >> top_gap[5:0];
   assign x        = s1_block_ff & len_mask;

   always_comb begin
      if (s1_first_ff) begin
         inv_mask = len_mask;
      end else begin
         case (prev_class_ff)
            CLASS_MORE_ZEROS: inv_mask = POS_EVERY_2ND >> top_gap[5:0];
            CLASS_MORE_ONES:  inv_mask = POS_EVERY_3RD >> top_gap[5:0];
            default:          inv_mask = len_mask;
         endcase
      end
   end

   assign inv_out = (x ^ inv_mask) & len_mask;

   always_comb begin
      if (direction_ff == DIR_ENCODE) begin
         rot_out = (x >> 1) | ((x & DATA_W'(1)) << len_m1[5:0]);
      end else begin
         rot_out = ((x << 1) & len_mask) | (x >> len_m1[5:0]);
      end
   end

   // class of the plaintext block
   assign plain = (direction_ff == DIR_ENCODE) ? x : inv_out;

   always_comb begin
      ones = '0;
      for (int b = 0; b < DATA_W; b++) begin
         ones = ones + LEN_W'(plain[b]);
      end
   end

   assign ones_x2 = {ones, 1'b0};

   always_comb begin
      if (ones_x2 == {1'b0, eff_len}) begin
         cur_class = CLASS_EQUAL;
      end else if (ones_x2 < {1'b0, eff_len}) begin
         cur_class = CLASS_MORE_ZEROS;
      end else begin
         cur_class = CLASS_MORE_ONES;
      end
   end

   always_comb begin
      prev_class_in = prev_class_ff;
      if (advance && method_ff == METHOD_INVERT) begin
         prev_class_in = cur_class;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_block_in = out_block_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
      end
      if (advance) begin
         out_block_in = (method_ff == METHOD_INVERT) ? inv_out : rot_out;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_block_out = out_block_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_len_ff  <= BLOCK_LEN_RESET;
         method_ff     <= METHOD_INVERT;
         direction_ff  <= DIR_ENCODE;
         prev_class_ff <= CLASS_EQUAL;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         block_len_ff  <= block_len_in;
         method_ff     <= method_in;
         direction_ff  <= direction_in;
         prev_class_ff <= prev_class_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_block_ff  <= s1_block_in;
      s1_first_ff  <= s1_first_in;
      out_block_ff <= out_block_in;
   end

endmodule : block_bit_inversion_codec
`default_nettype wire
